[hdl/llq_pkg.sv]
package llq_pkg;

   localparam int SlotsDefault = 64;
   localparam int KindWidth    = 3;
   localparam int SlotIdWidth  = 6;
   localparam int StatusWidth  = 2;

   localparam logic [KindWidth-1:0] KIND_PUSH_HEAD    = 3'd0;
   localparam logic [KindWidth-1:0] KIND_PUSH_TAIL    = 3'd1;
   localparam logic [KindWidth-1:0] KIND_POP_HEAD     = 3'd2;
   localparam logic [KindWidth-1:0] KIND_INSERT_AFTER = 3'd3;
   localparam logic [KindWidth-1:0] KIND_REMOVE_AFTER = 3'd4;
   localparam logic [KindWidth-1:0] KIND_REMOVE       = 3'd5;

   localparam logic [StatusWidth-1:0] STATUS_DONE      = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_NOP       = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [KindWidth-1:0]   kind;
      logic [SlotIdWidth-1:0] slot_id;
      logic [SlotIdWidth-1:0] anchor_id;
      logic                   anchor_valid;
   } req_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [SlotIdWidth-1:0] out_id;
      logic                   out_valid;
      logic                   is_empty;
      logic [SlotIdWidth-1:0] head_id;
      logic [SlotIdWidth-1:0] tail_id;
   } rsp_type;

endpackage

[hdl/llq_if.sv]
interface llq_req_if;
   logic             valid;
   logic             ready;
   llq_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface llq_rsp_if;
   logic             valid;
   logic             ready;
   llq_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[hdl/linked_list_queue_manager.sv]
// Single queue of slot ids kept as a singly linked list: the next pointer of
// every slot lives in a one-port-read, one-port-write link memory of SLOTS
// entries with registered read data, head and tail sit in flip-flops. One
// request is worked at a time; a request beat is taken while the previous
// result beat still waits in the output register. Each request goes from the
// execute state to the output state; push tail onto a non-empty queue, pop,
// insert after, remove after and remove by id pass through states between the
// two that read and write the link memory, and remove by id walks at most SLOTS
// links from the head. The output state holds while the previous result beat
// is not yet taken, and the next request beat can be taken once the result
// register loads. Pushing or inserting a slot that is already queued
// corrupts the list, and anchoring on a slot whose link was never written
// is not supported.
module linked_list_queue_manager #(
   parameter int SLOTS = llq_pkg::SlotsDefault
) (
   input logic       clock,
   input logic       reset,
   llq_req_if.sink   req_bus,
   llq_rsp_if.source rsp_bus
);
   import llq_pkg::*;

   localparam int IdWidth = $clog2(SLOTS);

   logic               mem_wr_en;
   logic [IdWidth-1:0] mem_wr_addr;
   logic [IdWidth:0]   mem_wr_data;
   logic               mem_rd_en;
   logic [IdWidth-1:0] mem_rd_addr;
   logic [IdWidth:0]   mem_rd_data;

   llq_ctrl #(
      .SLOTS (SLOTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   llq_link_ram #(
      .SLOTS (SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // an empty queue reports null head and tail
   a_empty_null: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.is_empty |->
         rsp_bus.data.head_id == '0 && rsp_bus.data.tail_id == '0)
      else $error("empty queue with non-null head or tail");

   // a slot comes out only on a completed request
   a_taken_done: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.data.out_valid |-> rsp_bus.data.status == STATUS_DONE)
      else $error("slot returned without done status");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request taken while previous one in flight");
endmodule

[hdl/llq_link_ram.sv]
module llq_link_ram #(
   parameter int SLOTS = llq_pkg::SlotsDefault
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   input  logic [$clog2(SLOTS):0]     wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   output logic [$clog2(SLOTS):0]     rd_data
);
   localparam int IdWidth   = $clog2(SLOTS);
   localparam int LinkWidth = IdWidth + 1;

   logic [LinkWidth-1:0] mem [SLOTS];
   logic [LinkWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/llq_ctrl.sv]
module llq_ctrl #(
   parameter int SLOTS = llq_pkg::SlotsDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   llq_req_if.sink                    req_bus,
   llq_rsp_if.source                  rsp_bus,
   output logic                       mem_wr_en,
   output logic [$clog2(SLOTS)-1:0]   mem_wr_addr,
   output logic [$clog2(SLOTS):0]     mem_wr_data,
   output logic                       mem_rd_en,
   output logic [$clog2(SLOTS)-1:0]   mem_rd_addr,
   input  logic [$clog2(SLOTS):0]     mem_rd_data
);
   import llq_pkg::*;

   localparam int IdWidth   = $clog2(SLOTS);
   localparam int LinkWidth = IdWidth + 1;
   localparam int ExtWidth  = IdWidth + SlotIdWidth;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_EXEC      = 4'd1;
   localparam logic [3:0] ST_PUSH_TAIL = 4'd2;
   localparam logic [3:0] ST_POP       = 4'd3;
   localparam logic [3:0] ST_INS_1     = 4'd4;
   localparam logic [3:0] ST_INS_2     = 4'd5;
   localparam logic [3:0] ST_RA_1      = 4'd6;
   localparam logic [3:0] ST_RA_2      = 4'd7;
   localparam logic [3:0] ST_RA_3      = 4'd8;
   localparam logic [3:0] ST_WALK_RD   = 4'd9;
   localparam logic [3:0] ST_WALK_CHK  = 4'd10;
   localparam logic [3:0] ST_WALK_CLR  = 4'd11;
   localparam logic [3:0] ST_OUT       = 4'd12;

   localparam logic [LinkWidth-1:0] LINK_NULL = '0;

   logic [3:0]             state_ff, state_in;
   logic [KindWidth-1:0]   kind_ff, kind_in;
   logic [IdWidth-1:0]     sid_ff, sid_in;
   logic [IdWidth-1:0]     aid_ff, aid_in;
   logic                   s_ok_ff, s_ok_in;
   logic                   a_ok_ff, a_ok_in;
   logic                   av_ff, av_in;
   logic [LinkWidth-1:0]   head_ff, head_in;
   logic [LinkWidth-1:0]   tail_ff, tail_in;
   logic [LinkWidth-1:0]   prev_ff, prev_in;
   logic [LinkWidth-1:0]   cur_ff, cur_in;
   logic [IdWidth:0]       cnt_ff, cnt_in;
   logic [StatusWidth-1:0] status_ff, status_in;
   logic [LinkWidth-1:0]   taken_ff, taken_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic [ExtWidth-1:0]    sid_ext;
   logic [ExtWidth-1:0]    aid_ext;
   logic [LinkWidth-1:0]   s_link;
   logic [LinkWidth-1:0]   a_link;
   logic [LinkWidth-1:0]   nx_link;
   logic [LinkWidth-1:0]   walk_head;
   logic [LinkWidth-1:0]   walk_tail;
   logic                   accept;

   assign sid_ext = {{IdWidth{1'b0}}, req_bus.data.slot_id};
   assign aid_ext = {{IdWidth{1'b0}}, req_bus.data.anchor_id};
   assign s_link  = {1'b1, sid_ff};
   assign a_link  = {1'b1, aid_ff};
   assign nx_link = mem_rd_data[IdWidth] ? mem_rd_data : LINK_NULL;
   assign accept  = req_bus.valid && req_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data  = rsp_data_ff;

   // head and tail after unlinking the found slot during a walk
   always_comb begin
      walk_head = prev_ff[IdWidth] ? head_ff : nx_link;
      walk_tail = (tail_ff == cur_ff) ? prev_ff : tail_ff;
      if (!walk_head[IdWidth]) begin
         walk_head = LINK_NULL;
         walk_tail = LINK_NULL;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      sid_in       = sid_ff;
      aid_in       = aid_ff;
      s_ok_in      = s_ok_ff;
      a_ok_in      = a_ok_ff;
      av_in        = av_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in  = rsp_data_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = sid_ff;
      mem_wr_data  = LINK_NULL;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = aid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_bus.data.kind;
               sid_in    = sid_ext[IdWidth-1:0];
               aid_in    = aid_ext[IdWidth-1:0];
               s_ok_in   = sid_ext < ExtWidth'(SLOTS);
               a_ok_in   = req_bus.data.anchor_valid && (aid_ext < ExtWidth'(SLOTS));
               av_in     = req_bus.data.anchor_valid;
               status_in = STATUS_NOP;
               taken_in  = LINK_NULL;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_OUT;
            case (kind_ff)
               KIND_PUSH_HEAD: begin
                  if (s_ok_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = sid_ff;
                     mem_wr_data = head_ff;
                     head_in     = s_link;
                     if (!tail_ff[IdWidth]) begin
                        tail_in = s_link;
                     end
                     status_in = STATUS_DONE;
                  end
               end
               KIND_PUSH_TAIL: begin
                  if (s_ok_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = sid_ff;
                     mem_wr_data = LINK_NULL;
                     status_in   = STATUS_DONE;
                     if (!head_ff[IdWidth]) begin
                        head_in = s_link;
                        tail_in = s_link;
                     end else begin
                        state_in = ST_PUSH_TAIL;
                     end
                  end
               end
               KIND_POP_HEAD, KIND_REMOVE_AFTER: begin
                  if (kind_ff == KIND_REMOVE_AFTER && av_ff) begin
                     if (a_ok_ff) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = aid_ff;
                        state_in    = ST_RA_1;
                     end
                  end else if (head_ff[IdWidth]) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff[IdWidth-1:0];
                     cur_in      = head_ff;
                     state_in    = ST_POP;
                  end
               end
               KIND_INSERT_AFTER: begin
                  if (s_ok_ff && a_ok_ff) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = aid_ff;
                     state_in    = ST_INS_1;
                  end
               end
               KIND_REMOVE: begin
                  if (s_ok_ff) begin
                     status_in = STATUS_NOT_FOUND;
                     prev_in   = LINK_NULL;
                     cur_in    = head_ff;
                     cnt_in    = '0;
                     state_in  = ST_WALK_RD;
                  end
               end
               default: begin
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_PUSH_TAIL: begin
            mem_wr_en   = tail_ff[IdWidth];
            mem_wr_addr = tail_ff[IdWidth-1:0];
            mem_wr_data = s_link;
            tail_in     = s_link;
            state_in    = ST_OUT;
         end
         ST_POP: begin
            head_in = nx_link;
            if (!nx_link[IdWidth]) begin
               tail_in = LINK_NULL;
            end
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_ff[IdWidth-1:0];
            mem_wr_data = LINK_NULL;
            taken_in    = cur_ff;
            status_in   = STATUS_DONE;
            state_in    = ST_OUT;
         end
         ST_INS_1: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = sid_ff;
            mem_wr_data = mem_rd_data;
            state_in    = ST_INS_2;
         end
         ST_INS_2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = aid_ff;
            mem_wr_data = s_link;
            if (tail_ff == a_link) begin
               tail_in = s_link;
            end
            status_in = STATUS_DONE;
            state_in  = ST_OUT;
         end
         ST_RA_1: begin
            if (mem_rd_data[IdWidth]) begin
               cur_in      = mem_rd_data;
               mem_rd_en   = 1'b1;
               mem_rd_addr = mem_rd_data[IdWidth-1:0];
               state_in    = ST_RA_2;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_RA_2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = aid_ff;
            mem_wr_data = mem_rd_data;
            if (tail_ff == cur_ff) begin
               tail_in = a_link;
            end
            state_in = ST_RA_3;
         end
         ST_RA_3: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_ff[IdWidth-1:0];
            mem_wr_data = LINK_NULL;
            taken_in    = cur_ff;
            status_in   = STATUS_DONE;
            state_in    = ST_OUT;
         end
         ST_WALK_RD: begin
            if (cnt_ff < (IdWidth + 1)'(SLOTS) && cur_ff[IdWidth]) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cur_ff[IdWidth-1:0];
               state_in    = ST_WALK_CHK;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_WALK_CHK: begin
            if (cur_ff == s_link) begin
               mem_wr_en   = prev_ff[IdWidth];
               mem_wr_addr = prev_ff[IdWidth-1:0];
               mem_wr_data = nx_link;
               head_in     = walk_head;
               tail_in     = walk_tail;
               taken_in    = cur_ff;
               status_in   = STATUS_DONE;
               state_in    = ST_WALK_CLR;
            end else begin
               prev_in  = cur_ff;
               cur_in   = mem_rd_data;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_CLR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_ff[IdWidth-1:0];
            mem_wr_data = LINK_NULL;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = status_ff;
               rsp_data_in.out_id    = SlotIdWidth'(taken_ff[IdWidth-1:0]);
               rsp_data_in.out_valid = taken_ff[IdWidth];
               rsp_data_in.is_empty  = !head_ff[IdWidth];
               rsp_data_in.head_id   = SlotIdWidth'(head_ff[IdWidth-1:0]);
               rsp_data_in.tail_id   = SlotIdWidth'(tail_ff[IdWidth-1:0]);
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= LINK_NULL;
         tail_ff      <= LINK_NULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      sid_ff      <= sid_in;
      aid_ff      <= aid_in;
      s_ok_ff     <= s_ok_in;
      a_ok_ff     <= a_ok_in;
      av_ff       <= av_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      taken_ff    <= taken_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

[tb/tb.sv]
module tb;
   import llq_pkg::*;

   localparam int SLOTS       = llq_pkg::SlotsDefault;
   localparam int GEN_VIEW    = 0;
   localparam int DUT_VIEW    = 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_WAIT  = 150;
   localparam int HOLD_CYCLES = 400;

   localparam logic [KindWidth-1:0] KIND_UNKNOWN_LO = 3'd6;
   localparam logic [KindWidth-1:0] KIND_UNKNOWN_HI = 3'd7;

   typedef logic [SlotIdWidth-1:0] slot_type;

   typedef struct packed {
      bit                   vld;
      bit [SlotIdWidth-1:0] id;
   } link_type;

   logic clock = 1'b0;
   logic reset;

   llq_req_if req_bus ();
   llq_rsp_if rsp_bus ();

   linked_list_queue_manager #(.SLOTS(SLOTS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // two copies of the list: one steers stimulus, one follows accepted beats
   link_type link_tab [2][SLOTS];
   bit       ever_linked [2][SLOTS];
   link_type head_ptr [2];
   link_type tail_ptr [2];

   req_type req_backlog [$];
   rsp_type rsp_expected [$];

   int send_idle_pct  = 0;
   int sink_stall_pct = 0;
   int depth_goal     = 8;
   int mismatch_count = 0;
   int cycle_count    = 0;
   bit req_fire       = 1'b0;
   bit pressure_on    = 1'b0;
   bit rsp_hold       = 1'b0;

   function automatic link_type link_read(int m, link_type at);
      if (!at.vld) return '0;
      return link_tab[m][at.id];
   endfunction

   function automatic void link_write(int m, link_type at, link_type val);
      if (at.vld) begin
         link_tab[m][at.id] = val;
         ever_linked[m][at.id] = 1'b1;
      end
   endfunction

   function automatic rsp_type queue_step(int m, req_type r);
      rsp_type                o;
      link_type               s;
      link_type               a;
      link_type               taken;
      link_type               p;
      link_type               prev;
      link_type               cur;
      link_type               nx;
      logic [StatusWidth-1:0] st;
      bit                     found;
      int                     i;
      s = '{vld: 1'b1, id: r.slot_id};
      a = '{vld: 1'b1, id: r.anchor_id};
      taken = '0;
      st = STATUS_NOP;
      if (r.kind == KIND_PUSH_HEAD) begin
         link_write(m, s, head_ptr[m]);
         head_ptr[m] = s;
         if (!tail_ptr[m].vld) tail_ptr[m] = s;
         st = STATUS_DONE;
      end else if (r.kind == KIND_PUSH_TAIL) begin
         link_write(m, s, '0);
         if (!head_ptr[m].vld) head_ptr[m] = s;
         else link_write(m, tail_ptr[m], s);
         tail_ptr[m] = s;
         st = STATUS_DONE;
      end else if (r.kind == KIND_POP_HEAD ||
                   (r.kind == KIND_REMOVE_AFTER && !r.anchor_valid)) begin
         taken = head_ptr[m];
         if (taken.vld) begin
            head_ptr[m] = link_read(m, taken);
            if (!head_ptr[m].vld) begin
               head_ptr[m] = '0;
               tail_ptr[m] = '0;
            end
            link_write(m, taken, '0);
            st = STATUS_DONE;
         end
      end else if (r.kind == KIND_INSERT_AFTER) begin
         if (r.anchor_valid) begin
            link_write(m, s, link_read(m, a));
            link_write(m, a, s);
            if (tail_ptr[m] == a) tail_ptr[m] = s;
            st = STATUS_DONE;
         end
      end else if (r.kind == KIND_REMOVE_AFTER) begin
         p = link_read(m, a);
         if (p.vld) begin
            link_write(m, a, link_read(m, p));
            if (tail_ptr[m] == p) tail_ptr[m] = a;
            link_write(m, p, '0);
            taken = p;
            st = STATUS_DONE;
         end
      end else if (r.kind == KIND_REMOVE) begin
         st = STATUS_NOT_FOUND;
         prev = '0;
         cur = head_ptr[m];
         found = 1'b0;
         // walk is bounded so a looped list still ends
         for (i = 0; i < SLOTS && cur.vld && !found; i++) begin
            if (cur == s) begin
               nx = link_read(m, cur);
               if (!nx.vld) nx = '0;
               if (!prev.vld) head_ptr[m] = nx;
               else link_write(m, prev, nx);
               if (tail_ptr[m] == cur) tail_ptr[m] = prev;
               if (!head_ptr[m].vld) begin
                  head_ptr[m] = '0;
                  tail_ptr[m] = '0;
               end
               link_write(m, cur, '0);
               taken = cur;
               st = STATUS_DONE;
               found = 1'b1;
            end else begin
               prev = cur;
               cur = link_read(m, cur);
            end
         end
      end
      o.status    = st;
      o.out_id    = taken.vld ? taken.id : '0;
      o.out_valid = taken.vld;
      o.is_empty  = !head_ptr[m].vld;
      o.head_id   = head_ptr[m].vld ? head_ptr[m].id : '0;
      o.tail_id   = tail_ptr[m].vld ? tail_ptr[m].id : '0;
      return o;
   endfunction

   function automatic req_type mk_req(logic [KindWidth-1:0] kind, slot_type sid,
                                      slot_type aid, logic av);
      req_type r;
      r.kind         = kind;
      r.slot_id      = sid;
      r.anchor_id    = aid;
      r.anchor_valid = av;
      return r;
   endfunction

   function automatic void offer(req_type r);
      void'(queue_step(GEN_VIEW, r));
      req_backlog.push_back(r);
   endfunction

   function automatic req_type pick_request();
      req_type  r;
      bit       on_list [SLOTS];
      slot_type members [$];
      slot_type free_ids [$];
      slot_type stale_ids [$];
      link_type cur;
      int       i;
      int       roll;
      int       n;
      int       push_pct;
      cur = head_ptr[GEN_VIEW];
      for (i = 0; i < SLOTS && cur.vld; i++) begin
         if (!on_list[cur.id]) begin
            on_list[cur.id] = 1'b1;
            members.push_back(cur.id);
         end
         cur = link_read(GEN_VIEW, cur);
      end
      for (i = 0; i < SLOTS; i++) begin
         if (!on_list[i]) begin
            free_ids.push_back(slot_type'(i));
            if (ever_linked[GEN_VIEW][i]) stale_ids.push_back(slot_type'(i));
         end
      end
      n = members.size();
      push_pct = (n < depth_goal) ? 60 : 15;
      r.kind         = KIND_POP_HEAD;
      r.slot_id      = slot_type'($urandom);
      r.anchor_id    = slot_type'($urandom);
      r.anchor_valid = 1'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         r.kind = $urandom_range(0, 1) ? KIND_UNKNOWN_LO : KIND_UNKNOWN_HI;
      end else if (roll < 5 && n != 0) begin
         // slot already on the list
         r.kind = $urandom_range(0, 1) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
         r.slot_id = members[$urandom_range(0, n - 1)];
      end else if (roll < 5 + push_pct && free_ids.size() != 0) begin
         r.kind = $urandom_range(0, 1) ? KIND_PUSH_HEAD : KIND_PUSH_TAIL;
         r.slot_id = free_ids[$urandom_range(0, free_ids.size() - 1)];
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            r.kind = KIND_POP_HEAD;
         end else if (roll < 40 && free_ids.size() != 0) begin
            r.kind = KIND_INSERT_AFTER;
            r.slot_id = free_ids[$urandom_range(0, free_ids.size() - 1)];
         end else if (roll < 65) begin
            r.kind = KIND_REMOVE_AFTER;
         end else begin
            r.kind = KIND_REMOVE;
            if (n != 0 && $urandom_range(0, 6) != 0)
               r.slot_id = members[$urandom_range(0, n - 1)];
         end
      end
      // anchors only on slots whose link was written at some point
      if (r.kind == KIND_INSERT_AFTER || r.kind == KIND_REMOVE_AFTER) begin
         roll = $urandom_range(0, 9);
         if (n != 0 && roll < 8) begin
            r.anchor_valid = 1'b1;
            r.anchor_id = members[$urandom_range(0, n - 1)];
         end else if (stale_ids.size() != 0 && roll < 9) begin
            r.anchor_valid = 1'b1;
            r.anchor_id = stale_ids[$urandom_range(0, stale_ids.size() - 1)];
         end else begin
            r.anchor_valid = 1'b0;
         end
      end
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_fire) begin
            if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.data  <= req_backlog.pop_front();
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= !reset && !rsp_hold && ($urandom_range(0, 99) >= sink_stall_pct);
   end

   // long hold-off on the result side so the block backs up
   initial begin
      wait (pressure_on);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // monitor: check result beats, then predict from accepted request beats
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      req_fire = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.data;
            if (rsp_expected.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat %h", got);
            end else begin
               want = rsp_expected.pop_front();
               if (got.status !== want.status || got.out_id !== want.out_id ||
                   got.out_valid !== want.out_valid || got.is_empty !== want.is_empty ||
                   got.head_id !== want.head_id || got.tail_id !== want.tail_id) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("mismatch: expected st=%0d id=%0d ov=%0b emp=%0b hd=%0d tl=%0d",
                            want.status, want.out_id, want.out_valid, want.is_empty,
                            want.head_id, want.tail_id);
                     $display(" got st=%0d id=%0d ov=%0b emp=%0b hd=%0d tl=%0d",
                              got.status, got.out_id, got.out_valid, got.is_empty,
                              got.head_id, got.tail_id);
                  end
               end
            end
         end
         req_fire = req_bus.valid && req_bus.ready;
         if (req_fire) rsp_expected.push_back(queue_step(DUT_VIEW, req_bus.data));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("linked_list_queue_manager verification failed");
         $finish;
      end
   end

   initial begin
      int phase;
      int k;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty queue, unknown kinds, missing anchor
      offer(mk_req(KIND_POP_HEAD, 6'd63, 6'd63, 1'b1));
      offer(mk_req(KIND_REMOVE_AFTER, 6'd0, 6'd21, 1'b0));
      offer(mk_req(KIND_REMOVE, 6'd5, 6'd0, 1'b0));
      offer(mk_req(KIND_UNKNOWN_LO, 6'd63, 6'd63, 1'b1));
      offer(mk_req(KIND_UNKNOWN_HI, 6'd0, 6'd0, 1'b0));
      offer(mk_req(KIND_INSERT_AFTER, 6'd3, 6'd7, 1'b0));
      // build 1 42 0 63, then insert at tail and in the middle
      offer(mk_req(KIND_PUSH_TAIL, 6'd0, 6'd63, 1'b1));
      offer(mk_req(KIND_PUSH_TAIL, 6'd63, 6'd0, 1'b0));
      offer(mk_req(KIND_PUSH_HEAD, 6'd42, 6'd0, 1'b0));
      offer(mk_req(KIND_PUSH_HEAD, 6'd1, 6'd63, 1'b1));
      offer(mk_req(KIND_INSERT_AFTER, 6'd17, 6'd63, 1'b1));
      offer(mk_req(KIND_INSERT_AFTER, 6'd5, 6'd42, 1'b1));
      // remove after the tail, in the middle, of the tail
      offer(mk_req(KIND_REMOVE_AFTER, 6'd0, 6'd17, 1'b1));
      offer(mk_req(KIND_REMOVE_AFTER, 6'd0, 6'd42, 1'b1));
      offer(mk_req(KIND_REMOVE_AFTER, 6'd0, 6'd63, 1'b1));
      // remove by id: absent, tail, head
      offer(mk_req(KIND_REMOVE, 6'd33, 6'd0, 1'b0));
      offer(mk_req(KIND_REMOVE, 6'd63, 6'd0, 1'b0));
      offer(mk_req(KIND_REMOVE, 6'd1, 6'd63, 1'b1));
      offer(mk_req(KIND_REMOVE_AFTER, 6'd9, 6'd9, 1'b0));
      offer(mk_req(KIND_POP_HEAD, 6'd0, 6'd0, 1'b0));
      offer(mk_req(KIND_REMOVE, 6'd0, 6'd0, 1'b0));
      // anchor that left the list
      offer(mk_req(KIND_INSERT_AFTER, 6'd9, 6'd42, 1'b1));
      offer(mk_req(KIND_REMOVE_AFTER, 6'd0, 6'd42, 1'b1));

      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               sink_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 72;
               sink_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               sink_stall_pct = 72;
            end
            default: begin
               send_idle_pct  = 24;
               sink_stall_pct = 24;
            end
         endcase
         if (phase == 4) pressure_on = 1'b1;
         for (k = 0; k < 92; k++) begin
            if (k % 46 == 0) depth_goal = $urandom_range(0, SLOTS);
            offer(pick_request());
         end
         while (req_backlog.size() != 0) @(posedge clock);
      end

      while (req_backlog.size() != 0 || req_bus.valid || rsp_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("linked_list_queue_manager verification clean");
      end else begin
         $display("linked_list_queue_manager verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
hdl/llq_pkg.sv
hdl/llq_if.sv
hdl/llq_link_ram.sv
hdl/llq_ctrl.sv
hdl/linked_list_queue_manager.sv
tb/tb.sv
